// ===== hdl/websocket_frame_deframer_assert.svh =====
// assertion macros shared by the deframer modules
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/wsfd_pkg.sv =====
`timescale 1ns / 1ps

package wsfd_pkg;

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT     = 6'b000100,
      PH_MASK    = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_STOP    = 6'b100000
   } phase_type;

   localparam logic [3:0] OPC_TEXT  = 4'h1;
   localparam logic [3:0] OPC_CLOSE = 4'h8;
   localparam logic [3:0] OPC_PING  = 4'h9;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_PING  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [1:0] frame_kind;
      logic       frame_end;
   } result_type;

endpackage

// ===== hdl/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps

// websocket frame deframer
// req channel: one received stream byte per transaction on req_rx_byte.
// rsp channel: one transaction per payload byte of a text or ping frame,
//   one per empty text or ping frame, and one close event at the end of a
//   close frame; other opcodes and header bytes give no transaction.
// a byte is taken in every cycle req_valid is high while req_ready is high;
// its result is written into the result buffer and shows on rsp_* from there.
// throughput is one byte per cycle while req_ready is high, set by the
// header/payload decision and 64-bit length down-counter in the parser.
// a two-entry result buffer sits before the rsp ports: while rsp_ready is
// low the block keeps taking bytes until both entries hold results, then
// req_ready drops until the receiver takes one.
// after a close event the parser ignores all further bytes until reset.
// reset (synchronous, active high) empties the buffer and returns the parser
// to expect the first header byte of a frame.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_byte_valid,
   output logic [1:0] rsp_frame_kind,
   output logic       rsp_frame_end
);
   import wsfd_pkg::*;

   logic       accept;
   logic       has_result;
   result_type result;
   result_type out_data;

   assign accept = req_valid && req_ready;

   wsfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .has_result (has_result),
      .result     (result)
   );

   wsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (has_result),
      .push_data (result),
      .space     (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_data_byte  = out_data.data_byte;
   assign rsp_byte_valid = out_data.byte_valid;
   assign rsp_frame_kind = out_data.frame_kind;
   assign rsp_frame_end  = out_data.frame_end;

endmodule

// ===== hdl/wsfd_parser.sv =====
`timescale 1ns / 1ps

module wsfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   output logic                 has_result,
   output wsfd_pkg::result_type result
);
   import wsfd_pkg::*;

   `include "websocket_frame_deframer_assert.svh"

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [2:0]  ext_left_ff, ext_left_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;

   logic        len_known;
   logic        empty_done;
   logic        last;
   logic [6:0]  len7;
   logic [7:0]  key_byte;

   assign len7 = rx_byte[6:0];

   always_comb begin
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      mask_in      = mask_ff;
      ext_left_in  = ext_left_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      len_known    = 1'b0;
      empty_done   = 1'b0;
      last         = 1'b0;
      has_result   = 1'b0;
      result       = '0;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: begin
               opcode_in = rx_byte[3:0];
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               mask_in = rx_byte[7];
               if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                  ext_left_in  = (len7 == LEN_EXT16) ? 3'd1 : 3'd7;
                  remaining_in = '0;
                  phase_in     = PH_EXT;
               end else begin
                  remaining_in = {57'd0, len7};
                  len_known    = 1'b1;
               end
            end
            PH_EXT: begin
               remaining_in = {remaining_ff[55:0], rx_byte};
               if (ext_left_ff == 3'd0) begin
                  len_known = 1'b1;
               end else begin
                  ext_left_in = ext_left_ff - 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               pos_in = pos_ff + 2'd1;
               if (pos_in == 2'd0) begin
                  if (remaining_ff == 64'd0) begin
                     empty_done = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               pos_in       = pos_ff + 2'd1;
               remaining_in = remaining_ff - 64'd1;
               last         = (remaining_ff == 64'd1);
               if (last) begin
                  phase_in = PH_HDR0;
               end
               result.data_byte  = rx_byte ^ (mask_ff ? key_byte : 8'd0);
               result.byte_valid = 1'b1;
               result.frame_end  = last;
               if (opcode_ff == OPC_TEXT) begin
                  has_result        = 1'b1;
                  result.frame_kind = KIND_TEXT;
               end else if (opcode_ff == OPC_PING) begin
                  has_result        = 1'b1;
                  result.frame_kind = KIND_PING;
               end else if (opcode_ff == OPC_CLOSE && last) begin
                  has_result = 1'b1;
                  phase_in   = PH_STOP;
                  result     = '{data_byte: 8'd0, byte_valid: 1'b0,
                                 frame_kind: KIND_CLOSE, frame_end: 1'b1};
               end else begin
                  result = '0;
               end
            end
            PH_STOP: begin
               phase_in = PH_STOP;
            end
            default: begin
               phase_in = PH_STOP;
            end
         endcase

         if (len_known) begin
            key_in = '0;
            pos_in = '0;
            if (mask_in) begin
               phase_in = PH_MASK;
            end else if (remaining_in == 64'd0) begin
               empty_done = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         if (empty_done) begin
            phase_in          = PH_HDR0;
            result.data_byte  = 8'd0;
            result.byte_valid = 1'b0;
            result.frame_end  = 1'b1;
            if (opcode_ff == OPC_TEXT) begin
               has_result        = 1'b1;
               result.frame_kind = KIND_TEXT;
            end else if (opcode_ff == OPC_PING) begin
               has_result        = 1'b1;
               result.frame_kind = KIND_PING;
            end else if (opcode_ff == OPC_CLOSE) begin
               has_result        = 1'b1;
               result.frame_kind = KIND_CLOSE;
               phase_in          = PH_STOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         opcode_ff    <= '0;
         mask_ff      <= 1'b0;
         ext_left_ff  <= '0;
         remaining_ff <= '0;
         key_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         mask_ff      <= mask_in;
         ext_left_ff  <= ext_left_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         pos_ff       <= pos_in;
      end
   end

   `WSFD_ASSERT_NOW(a_stop_silent, accept && phase_ff == PH_STOP, !has_result,
      "stopped parser produced a result")
   `WSFD_ASSERT_NEXT(a_close_stops, has_result && result.frame_kind == KIND_CLOSE,
      phase_ff == PH_STOP, "close event did not stop the parser")
   `WSFD_ASSERT_NOW(a_empty_ends, has_result && !result.byte_valid,
      result.frame_end && result.data_byte == 8'd0, "byteless result not at frame end")

endmodule

// ===== hdl/wsfd_out_buf.sv =====
`timescale 1ns / 1ps

module wsfd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wsfd_pkg::result_type push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output wsfd_pkg::result_type out_data
);
   import wsfd_pkg::*;

   `include "websocket_frame_deframer_assert.svh"

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   `WSFD_ASSERT_NOW(a_no_overflow, push, space || pop, "result pushed into full buffer")
   `WSFD_ASSERT_NOW(a_ptr_count, 1'b1,
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff), "pointers disagree with count")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import wsfd_pkg::*;

   class deframer_scoreboard;
      phase_type   phase = PH_HDR0;
      logic [3:0]  opcode = '0;
      logic        masked = 1'b0;
      logic [2:0]  ext_left = '0;
      logic [63:0] remaining = '0;
      logic [31:0] key = '0;
      logic [1:0]  key_pos = '0;
      result_type  expected_results[$];
      int unsigned error_count = 0;

      function void push_result(logic [7:0] data, logic valid, logic [1:0] kind, logic done);
         result_type r;
         r.data_byte = data;
         r.byte_valid = valid;
         r.frame_kind = kind;
         r.frame_end = done;
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void end_empty_frame();
         phase = PH_HDR0;
         if (opcode == OPC_TEXT) begin
            push_result(8'h00, 1'b0, KIND_TEXT, 1'b1);
         end else if (opcode == OPC_PING) begin
            push_result(8'h00, 1'b0, KIND_PING, 1'b1);
         end else if (opcode == OPC_CLOSE) begin
            phase = PH_STOP;
            push_result(8'h00, 1'b0, KIND_CLOSE, 1'b1);
         end
      endfunction

      function void length_known();
         key = '0;
         key_pos = '0;
         if (masked) begin
            phase = PH_MASK;
         end else if (remaining == 0) begin
            end_empty_frame();
         end else begin
            phase = PH_PAYLOAD;
         end
      endfunction

      // advance the parser by one accepted byte and queue what it produces
      function void note_rx_byte(logic [7:0] b);
         logic [7:0] k;
         logic [7:0] plain;
         logic       is_last;
         case (phase)
            PH_HDR0: begin
               opcode = b[3:0];
               phase = PH_HDR1;
            end
            PH_HDR1: begin
               masked = b[7];
               if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                  ext_left = (b[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
                  remaining = '0;
                  phase = PH_EXT;
               end else begin
                  remaining = {57'b0, b[6:0]};
                  length_known();
               end
            end
            PH_EXT: begin
               remaining = {remaining[55:0], b};
               if (ext_left == 0) begin
                  length_known();
               end else begin
                  ext_left--;
               end
            end
            PH_MASK: begin
               key = {key[23:0], b};
               key_pos++;
               if (key_pos == 0) begin
                  if (remaining == 0) begin
                     end_empty_frame();
                  end else begin
                     phase = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               k = masked ? key[8 * (3 - int'(key_pos)) +: 8] : 8'h00;
               plain = b ^ k;
               key_pos++;
               remaining--;
               is_last = (remaining == 0);
               if (is_last) begin
                  phase = PH_HDR0;
               end
               if (opcode == OPC_TEXT) begin
                  push_result(plain, 1'b1, KIND_TEXT, is_last);
               end else if (opcode == OPC_PING) begin
                  push_result(plain, 1'b1, KIND_PING, is_last);
               end else if (opcode == OPC_CLOSE && is_last) begin
                  phase = PH_STOP;
                  push_result(8'h00, 1'b0, KIND_CLOSE, 1'b1);
               end
            end
            default: begin
               phase = PH_STOP;
            end
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result data_byte %02h byte_valid %0d frame_kind %0d frame_end %0d",
                     $time, got.data_byte, got.byte_valid, got.frame_kind, got.frame_end);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (got.data_byte !== want.data_byte) begin
            $display("%0t: data_byte expected %02h actual %02h",
                     $time, want.data_byte, got.data_byte);
            error_count++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %0d actual %0d",
                     $time, want.byte_valid, got.byte_valid);
            error_count++;
         end
         if (got.frame_kind !== want.frame_kind) begin
            $display("%0t: frame_kind expected %0d actual %0d",
                     $time, want.frame_kind, got.frame_kind);
            error_count++;
         end
         if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0d actual %0d",
                     $time, want.frame_end, got.frame_end);
            error_count++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic [1:0] rsp_frame_kind;
   logic       rsp_frame_end;

   deframer_scoreboard sb = new();
   int unsigned burst_left = 0;
   int unsigned bytes_sent = 0;

   websocket_frame_deframer uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_frame_end  (rsp_frame_end)
   );

   always #5 clock = ~clock;

   // both channels are observed in one place so input notes precede result checks
   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_rx_byte(req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got.data_byte = rsp_data_byte;
            got.byte_valid = rsp_byte_valid;
            got.frame_kind = rsp_frame_kind;
            got.frame_end = rsp_frame_end;
            sb.check_result(got);
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      bytes_sent++;
   endtask

   // form 0 short length, 1 16-bit extended, 2 64-bit extended
   task automatic send_frame(input logic [7:0] first, input logic masked, input int form,
                             input logic [63:0] len);
      logic [31:0]     key;
      longint unsigned i;
      key = $urandom;
      send_byte(first);
      case (form)
         0: begin
            send_byte({masked, len[6:0]});
         end
         1: begin
            send_byte({masked, LEN_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, LEN_EXT64});
            for (int n = 7; n >= 0; n--) send_byte(len[8 * n +: 8]);
         end
      endcase
      if (masked) begin
         for (int n = 3; n >= 0; n--) send_byte(key[8 * n +: 8]);
      end
      for (i = 0; i < len; i++) send_byte(8'($urandom));
   endtask

   task automatic random_frame();
      int          pick;
      logic [3:0]  opc;
      logic        masked;
      int          form;
      logic [63:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         opc = OPC_TEXT;
      end else if (pick < 75) begin
         opc = OPC_PING;
      end else begin
         do opc = 4'($urandom); while (opc == OPC_TEXT || opc == OPC_PING || opc == OPC_CLOSE);
      end
      masked = ($urandom_range(0, 9) < 7);
      pick = $urandom_range(0, 99);
      form = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
      if ($urandom_range(0, 9) == 0) begin
         len = '0;
      end else if (form == 0) begin
         len = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(21, 125)
                                               : $urandom_range(1, 20));
      end else if ($urandom_range(0, 15) == 0) begin
         len = 64'($urandom_range(250, 300));
      end else begin
         len = 64'($urandom_range(0, 40));
      end
      send_frame({4'($urandom), opc}, masked, form, len);
   endtask

   // receiver stall pattern, with one forced long hold-off early in the run plus random long hold-offs
   initial begin : receiver
      int mode;
      int span;
      int segment;
      segment = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 9);
         span = $urandom_range(5, 80);
         if (segment == 4 || (mode == 9 && $urandom_range(0, 3) == 0)) begin
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
         end else begin
            for (int c = 0; c < span; c++) begin
               if (mode < 4) begin
                  rsp_ready <= 1'b1;
               end else if (mode < 7) begin
                  rsp_ready <= ($urandom_range(0, 3) != 0);
               end else if (mode < 9) begin
                  rsp_ready <= (c % 3 == 0);
               end else begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               @(posedge clock);
            end
         end
         segment++;
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty text, empty masked ping without fin, dropped opcode, masked text,
      // ping with reserved bits and a 16-bit length
      send_frame({4'h8, OPC_TEXT}, 1'b0, 0, 64'd0);
      send_frame({4'h0, OPC_PING}, 1'b1, 0, 64'd0);
      send_frame(8'hFF, 1'b0, 0, 64'd1);
      send_frame({4'h8, OPC_TEXT}, 1'b1, 0, 64'd2);
      send_frame({4'hF, OPC_PING}, 1'b0, 1, 64'd1);

      while (bytes_sent < 930) random_frame();

      // close ends parsing; the trailing bytes must be ignored
      send_frame({4'($urandom), OPC_CLOSE}, 1'($urandom), $urandom_range(0, 1),
                 64'($urandom_range(0, 5)));
      repeat (8) send_byte(8'($urandom));
      req_valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/wsfd_pkg.sv
hdl/wsfd_parser.sv
hdl/wsfd_out_buf.sv
hdl/websocket_frame_deframer.sv
bench/tb_top.sv
